>>> rtl/core/kvl_pkg.sv
package kvl_pkg;

    localparam int KEY_COUNT_W      = 7;
    localparam int INDEX_W          = 6;
    localparam int TIME_W           = 32;
    localparam int VAL_W            = 32;
    localparam int SEG_W            = 6;
    localparam int FRAC_BITS        = 24;
    localparam int NUM_COMP         = 3;
    localparam int COMP_W           = 2;
    localparam int DIV_CNT_W        = $clog2(FRAC_BITS + 1);
    localparam int MAX_KEYS_DEFAULT = 64;

    // Fraction value that stands for exactly one.
    localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_BEFORE = 2'd1,
        STATUS_AFTER  = 2'd2,
        STATUS_ERR    = 2'd3
    } status_t;

    typedef struct packed {
        logic                      func;
        logic [INDEX_W-1:0]        key_index;
        logic [TIME_W-1:0]         key_time;
        logic signed [VAL_W-1:0]   key_x;
        logic signed [VAL_W-1:0]   key_y;
        logic signed [VAL_W-1:0]   key_z;
        logic [TIME_W-1:0]         query_time;
    } req_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]   out_x;
        logic signed [VAL_W-1:0]   out_y;
        logic signed [VAL_W-1:0]   out_z;
        logic [SEG_W-1:0]          segment;
        status_t                   status;
    } rsp_item_t;

endpackage

>>> rtl/core/kvl_req_if.sv
interface kvl_req_if;

    logic                 valid;
    logic                 ready;
    kvl_pkg::req_item_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

>>> rtl/core/kvl_rsp_if.sv
interface kvl_rsp_if;

    logic                 valid;
    logic                 ready;
    kvl_pkg::rsp_item_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

>>> rtl/core/keyframe_vector_lerp_unit.sv
// Keyframe track with linear interpolation of an xyz vector.
// The req channel carries one item per operation. A write item (func clear)
// stores key_time and key_x/y/z into slot key_index and gives no result. A
// query item (func set) gives exactly one result on the rsp channel: the
// vector interpolated at query_time, the lower key of the segment used and
// a status (ok, clamped before start, clamped after end, error).
// key_count is set through key_count_we/key_count_wdata; the user must do so
// only while the block is idle, as the block itself does not enforce it.
// A query searches the key times one per cycle, from the first segment up to
// the matching one. States S_LOAD1, S_LOAD2 and S_LOAD3 then fetch the two
// keys, a restoring divider forms the fraction (one quotient bit per cycle),
// and one shared multiplier handles the three components in turn, each
// through S_DIFF, S_MUL and S_ACC. Clamped queries skip the divider; an empty
// track goes straight to the result, and a single-key track answers after
// loading its key.
// req.ready is high only while the sequencer is idle. The result sits in an
// output register, so the block takes new items while a result waits; a
// finished query stalls only if the previous result has not yet been taken.
// Reset clears key_count and the control state; key memories are not cleared,
// and a slot must be written before a query reads it.
module keyframe_vector_lerp_unit #(
    parameter int MAX_KEYS = kvl_pkg::MAX_KEYS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            key_count_we,
    input  logic [kvl_pkg::KEY_COUNT_W-1:0] key_count_wdata,
    kvl_req_if.sink                         req,
    kvl_rsp_if.source                       rsp
);

    localparam int AW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int NW    = $clog2(MAX_KEYS + 1);
    localparam int CW    = (NW > kvl_pkg::KEY_COUNT_W) ? NW : kvl_pkg::KEY_COUNT_W;
    localparam int VW    = kvl_pkg::VAL_W;
    localparam int TW    = kvl_pkg::TIME_W;
    localparam int FB    = kvl_pkg::FRAC_BITS;
    localparam int NC    = kvl_pkg::NUM_COMP;
    localparam int CMW   = kvl_pkg::COMP_W;
    localparam int DCW   = kvl_pkg::DIV_CNT_W;
    localparam int VEC_W = NC * VW;
    localparam int PW    = VW + 1 + FB + 2;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_SEARCH = 10'b0000000010,
        S_LOAD1  = 10'b0000000100,
        S_LOAD2  = 10'b0000001000,
        S_LOAD3  = 10'b0000010000,
        S_DIV    = 10'b0000100000,
        S_DIFF   = 10'b0001000000,
        S_MUL    = 10'b0010000000,
        S_ACC    = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    // Control registers.
    state_t                             state_reg, state_next;
    logic                               out_valid_reg, out_valid_next;
    logic [kvl_pkg::KEY_COUNT_W-1:0]    key_count_reg;

    // Datapath registers.
    logic [AW-1:0]                      k_reg, k_next;
    logic                               single_reg, single_next;
    logic [TW-1:0]                      q_reg, q_next;
    logic [TW-1:0]                      t1_reg, t1_next;
    logic [TW-1:0]                      t2_reg, t2_next;
    logic [TW-1:0]                      d_reg, d_next;
    logic [TW:0]                        rem_reg, rem_next;
    logic [DCW-1:0]                     cnt_reg, cnt_next;
    logic [FB:0]                        f_reg, f_next;
    logic [CMW-1:0]                     comp_reg, comp_next;
    logic signed [VW-1:0]               v1_reg [NC];
    logic signed [VW-1:0]               v1_next [NC];
    logic signed [VW-1:0]               v2_reg [NC];
    logic signed [VW-1:0]               v2_next [NC];
    logic signed [VW-1:0]               res_reg [NC];
    logic signed [VW-1:0]               res_next [NC];
    logic signed [VW:0]                 diff_reg, diff_next;
    logic signed [PW-1:0]               prod_reg, prod_next;
    logic [kvl_pkg::SEG_W-1:0]          seg_reg, seg_next;
    kvl_pkg::status_t                   st_reg, st_next;
    kvl_pkg::rsp_item_t                 out_reg, out_next;

    // Memory ports.
    logic                               wr_en;
    logic [AW-1:0]                      wr_addr;
    logic [AW-1:0]                      t_raddr;
    logic [AW-1:0]                      v_raddr;
    logic [TW-1:0]                      t_rdata;
    logic [VEC_W-1:0]                   v_rdata;

    // Derived values.
    logic                               accept;
    logic                               out_load;
    logic [CW-1:0]                      kc_ext;
    logic [NW-1:0]                      n_keys;
    logic [NW-1:0]                      last_k;
    logic                               found;
    logic                               div_ge;
    logic [TW:0]                        div_sub;

    assign req.ready   = (state_reg == S_IDLE);
    assign accept      = req.valid && req.ready;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    // Effective key count, saturated to the track size.
    assign kc_ext = CW'(key_count_reg);
    assign n_keys = (kc_ext > CW'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(kc_ext);
    assign last_k = n_keys - NW'(2);

    // The search stops at the first key time above the query, or at the last segment.
    assign found = (q_reg < t_rdata) || (NW'(k_reg) == last_k);

    // Restoring divider step: one quotient bit of (q - t1) / (t2 - t1) per cycle.
    assign div_ge  = (rem_reg >= {1'b0, d_reg});
    assign div_sub = div_ge ? (rem_reg - {1'b0, d_reg}) : rem_reg;

    // Writes to slots beyond the track are dropped.
    assign wr_en   = accept && (req.payload.func == kvl_pkg::FUNC_WRITE)
                     && (32'(req.payload.key_index) < 32'(MAX_KEYS));
    assign wr_addr = AW'(req.payload.key_index);

    always_comb
    begin
        case (state_reg)
            S_IDLE:   t_raddr = AW'(1);
            S_SEARCH: t_raddr = k_reg + AW'(2);
            default:  t_raddr = k_reg;
        endcase
        if (state_reg == S_LOAD2)
        begin
            v_raddr = k_reg + AW'(1);
        end
        else
        begin
            v_raddr = k_reg;
        end
    end

    kvl_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_KEYS)
    ) u_time_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (req.payload.key_time),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    kvl_ram #(
        .WIDTH (VEC_W),
        .DEPTH (MAX_KEYS)
    ) u_vec_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata ({req.payload.key_z, req.payload.key_y, req.payload.key_x}),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        single_next = single_reg;
        q_next      = q_reg;
        t1_next     = t1_reg;
        t2_next     = t2_reg;
        d_next      = d_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        f_next      = f_reg;
        comp_next   = comp_reg;
        diff_next   = diff_reg;
        prod_next   = prod_reg;
        seg_next    = seg_reg;
        st_next     = st_reg;
        out_load    = 1'b0;
        for (int c = 0; c < NC; c++)
        begin
            v1_next[c]  = v1_reg[c];
            v2_next[c]  = v2_reg[c];
            res_next[c] = res_reg[c];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req.payload.func == kvl_pkg::FUNC_QUERY))
                begin
                    q_next      = req.payload.query_time;
                    k_next      = '0;
                    comp_next   = '0;
                    single_next = 1'b0;
                    if (n_keys == '0)
                    begin
                        for (int c = 0; c < NC; c++)
                        begin
                            res_next[c] = '0;
                        end
                        seg_next   = '0;
                        st_next    = kvl_pkg::STATUS_ERR;
                        state_next = S_DONE;
                    end
                    else if (n_keys == NW'(1))
                    begin
                        single_next = 1'b1;
                        state_next  = S_LOAD1;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                t2_next = t_rdata;
                if (found)
                begin
                    state_next = S_LOAD1;
                end
                else
                begin
                    k_next = k_reg + AW'(1);
                end
            end

            S_LOAD1:
            begin
                state_next = S_LOAD2;
            end

            S_LOAD2:
            begin
                t1_next = t_rdata;
                for (int c = 0; c < NC; c++)
                begin
                    v1_next[c] = v_rdata[c*VW +: VW];
                end
                if (single_reg)
                begin
                    for (int c = 0; c < NC; c++)
                    begin
                        res_next[c] = v_rdata[c*VW +: VW];
                    end
                    seg_next   = '0;
                    st_next    = kvl_pkg::STATUS_OK;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_LOAD3;
                end
            end

            S_LOAD3:
            begin
                for (int c = 0; c < NC; c++)
                begin
                    v2_next[c] = v_rdata[c*VW +: VW];
                end
                seg_next = kvl_pkg::SEG_W'(k_reg);
                if (t2_reg <= t1_reg)
                begin
                    for (int c = 0; c < NC; c++)
                    begin
                        res_next[c] = '0;
                    end
                    st_next    = kvl_pkg::STATUS_ERR;
                    state_next = S_DONE;
                end
                else if (q_reg < t1_reg)
                begin
                    f_next     = '0;
                    st_next    = kvl_pkg::STATUS_BEFORE;
                    state_next = S_DIFF;
                end
                else if (q_reg > t2_reg)
                begin
                    f_next     = kvl_pkg::FRAC_ONE;
                    st_next    = kvl_pkg::STATUS_AFTER;
                    state_next = S_DIFF;
                end
                else
                begin
                    rem_next   = {1'b0, q_reg - t1_reg};
                    d_next     = t2_reg - t1_reg;
                    cnt_next   = DCW'(FB);
                    f_next     = '0;
                    st_next    = kvl_pkg::STATUS_OK;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                rem_next = {div_sub[TW-1:0], 1'b0};
                f_next   = {f_reg[FB-1:0], div_ge};
                if (cnt_reg == '0)
                begin
                    state_next = S_DIFF;
                end
                else
                begin
                    cnt_next = cnt_reg - DCW'(1);
                end
            end

            S_DIFF:
            begin
                diff_next  = {v2_reg[comp_reg][VW-1], v2_reg[comp_reg]}
                             - {v1_reg[comp_reg][VW-1], v1_reg[comp_reg]};
                state_next = S_MUL;
            end

            S_MUL:
            begin
                prod_next  = PW'(diff_reg * $signed({1'b0, f_reg}));
                state_next = S_ACC;
            end

            S_ACC:
            begin
                // Bits above the fraction are the floor of the scaled difference.
                res_next[comp_reg] = v1_reg[comp_reg] + prod_reg[FB +: VW];
                if (comp_reg == CMW'(NC - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    comp_next  = comp_reg + CMW'(1);
                    state_next = S_DIFF;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_next         = out_reg;
        out_valid_next   = out_valid_reg;
        if (out_load)
        begin
            out_next.out_x   = res_reg[0];
            out_next.out_y   = res_reg[1];
            out_next.out_z   = res_reg[2];
            out_next.segment = seg_reg;
            out_next.status  = st_reg;
            out_valid_next   = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            key_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (key_count_we)
            begin
                key_count_reg <= key_count_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        single_reg <= single_next;
        q_reg      <= q_next;
        t1_reg     <= t1_next;
        t2_reg     <= t2_next;
        d_reg      <= d_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        f_reg      <= f_next;
        comp_reg   <= comp_next;
        diff_reg   <= diff_next;
        prod_reg   <= prod_next;
        seg_reg    <= seg_next;
        st_reg     <= st_next;
        out_reg    <= out_next;
        for (int c = 0; c < NC; c++)
        begin
            v1_reg[c]  <= v1_next[c];
            v2_reg[c]  <= v2_next[c];
            res_reg[c] <= res_next[c];
        end
    end

    // The divider only runs on a segment of positive length.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (d_reg != '0))
        else $error("divider running with a zero divisor");

    // The partial remainder stays below twice the divisor.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> ({1'b0, rem_reg} < {1'b0, d_reg, 1'b0}))
        else $error("divider remainder out of range");

    // The fraction never exceeds one.
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (f_reg <= kvl_pkg::FRAC_ONE))
        else $error("interpolation fraction above one");

    // An error result carries a zero vector.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status == kvl_pkg::STATUS_ERR))
        |-> ((out_reg.out_x == '0) && (out_reg.out_y == '0) && (out_reg.out_z == '0)))
        else $error("error result with a nonzero vector");

    // A keyframe write keeps the sequencer idle.
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.payload.func == kvl_pkg::FUNC_WRITE)) |=> (state_reg == S_IDLE))
        else $error("keyframe write started a query");

endmodule

>>> rtl/core/kvl_ram.sv
// Simple dual-port memory: one write port, one read port with registered data.
module kvl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> verif/keyframe_vector_lerp_unit_tb.sv
`timescale 1ns / 1ps

module keyframe_vector_lerp_unit_tb;

    localparam int NKEYS       = kvl_pkg::MAX_KEYS_DEFAULT;
    localparam int CYCLE_LIMIT = 1_000_000;
    // Settling time after the last result, covering any work still running.
    localparam int SETTLE_CYCLES = 120;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int HOLD_CYCLES   = 1000;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            key_count_we;
    logic [kvl_pkg::KEY_COUNT_W-1:0] key_count_wdata;

    kvl_req_if req ();
    kvl_rsp_if rsp ();

    keyframe_vector_lerp_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .key_count_we    (key_count_we),
        .key_count_wdata (key_count_wdata),
        .req             (req.sink),
        .rsp             (rsp.source)
    );

    // Items waiting to go out on the request channel, and the interpolation
    // results that accepted queries still owe us, oldest first.
    kvl_pkg::req_item_t items_to_send[$];
    kvl_pkg::rsp_item_t answers_due[$];

    // The testbench's own copy of the track, updated as items are accepted.
    logic [kvl_pkg::TIME_W-1:0]       ktime [NKEYS];
    logic signed [kvl_pkg::VAL_W-1:0] kvec  [NKEYS][kvl_pkg::NUM_COMP];
    int unsigned                      track_len;

    // The stimulus side keeps a plan of the key times it has sent, so that
    // query times can be aimed at keys and segment boundaries.
    logic [kvl_pkg::TIME_W-1:0] plan_time [NKEYS];

    // Idle knobs, in percent, changed only between phases.
    int unsigned req_idle_pct;
    int unsigned rsp_stall_pct;

    // Long output hold-off request and the stall counter that serves it.
    logic        hold_off_go;
    logic        hold_off_done;
    int unsigned hold_left;

    int unsigned cycle_count = 0;
    int unsigned err_count;
    int unsigned results_checked;
    int unsigned writes_sent;
    int unsigned queries_sent;
    int unsigned settings_used;
    int unsigned status_seen [4];

    always #5 clk = ~clk;

    // One blend of a component: v1 + floor((v2 - v1) * f / 2^24). The span
    // needs 33 bits and the product stays within 58, so 64-bit math is exact.
    function automatic logic signed [kvl_pkg::VAL_W-1:0] lerp_comp(
        input logic signed [kvl_pkg::VAL_W-1:0] v1,
        input logic signed [kvl_pkg::VAL_W-1:0] v2,
        input longint                           f
    );
        longint span;
        longint prod;
        span = longint'(v2) - longint'(v1);
        prod = span * f;
        return kvl_pkg::VAL_W'(longint'(v1) + (prod >>> kvl_pkg::FRAC_BITS));
    endfunction

    // Apply one accepted item to the local track. A write updates a slot; a
    // query pushes the one result it must produce.
    function automatic void track_step(input kvl_pkg::req_item_t it);
        kvl_pkg::rsp_item_t r;
        int unsigned        n;
        int unsigned        i;
        int unsigned        k;
        int                 c;
        longint unsigned    q;
        longint unsigned    t1;
        longint unsigned    t2;
        longint unsigned    f;
        if (it.func == kvl_pkg::FUNC_WRITE)
        begin
            ktime[it.key_index]   = it.key_time;
            kvec[it.key_index][0] = it.key_x;
            kvec[it.key_index][1] = it.key_y;
            kvec[it.key_index][2] = it.key_z;
            return;
        end
        r = '0;
        n = (track_len > NKEYS) ? NKEYS : track_len;
        q = it.query_time;
        if (n == 0)
        begin
            r.status = kvl_pkg::STATUS_ERR;
        end
        else if (n == 1)
        begin
            // A single key answers with itself, whatever the time.
            r.out_x  = kvec[0][0];
            r.out_y  = kvec[0][1];
            r.out_z  = kvec[0][2];
            r.status = kvl_pkg::STATUS_OK;
        end
        else
        begin
            // First segment whose upper key lies beyond the query time,
            // falling back to the last segment.
            i = n - 2;
            for (k = 0; k + 1 < n; k++)
            begin
                if (q < ktime[k + 1])
                begin
                    i = k;
                    break;
                end
            end
            t1 = ktime[i];
            t2 = ktime[i + 1];
            r.segment = kvl_pkg::SEG_W'(i);
            if (t2 <= t1)
            begin
                // Flat or backward segment: no fraction can be formed.
                r.status = kvl_pkg::STATUS_ERR;
            end
            else
            begin
                if (q < t1)
                begin
                    f        = 0;
                    r.status = kvl_pkg::STATUS_BEFORE;
                end
                else if (q > t2)
                begin
                    f        = kvl_pkg::FRAC_ONE;
                    r.status = kvl_pkg::STATUS_AFTER;
                end
                else
                begin
                    f        = ((q - t1) << kvl_pkg::FRAC_BITS) / (t2 - t1);
                    r.status = kvl_pkg::STATUS_OK;
                end
                for (c = 0; c < kvl_pkg::NUM_COMP; c++)
                begin
                    case (c)
                        0: r.out_x = lerp_comp(kvec[i][c], kvec[i + 1][c], f);
                        1: r.out_y = lerp_comp(kvec[i][c], kvec[i + 1][c], f);
                        default: r.out_z = lerp_comp(kvec[i][c], kvec[i + 1][c], f);
                    endcase
                end
            end
        end
        answers_due.push_back(r);
    endfunction

    // Request driver. The item on the bus at an accepting edge goes to the
    // local track; the next one is offered unless the sender chooses to idle.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req.valid   <= 1'b0;
            req.payload <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
                track_step(req.payload);
            if (!req.valid || req.ready)
            begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= req_idle_pct)
                begin
                    req.payload <= items_to_send.pop_front();
                    req.valid   <= 1'b1;
                end
                else
                begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // Result ready. A long hold-off, once requested, takes precedence over
    // the random stalls so the block has to back up into its input.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready     <= 1'b0;
            hold_left     <= 0;
            hold_off_done <= 1'b0;
        end
        else if (hold_off_go && !hold_off_done)
        begin
            rsp.ready     <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_off_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            rsp.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // Result monitor: every accepted result is matched against the oldest
    // outstanding query.
    always @(posedge clk)
    begin
        kvl_pkg::rsp_item_t exp_r;
        kvl_pkg::rsp_item_t got_r;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got_r = rsp.payload;
            if (answers_due.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("[%0t] unexpected result: x=%h y=%h z=%h seg=%0d status=%0d",
                             $realtime, got_r.out_x, got_r.out_y, got_r.out_z,
                             got_r.segment, got_r.status);
            end
            else
            begin
                exp_r = answers_due.pop_front();
                results_checked++;
                status_seen[exp_r.status]++;
                if (got_r.out_x !== exp_r.out_x || got_r.out_y !== exp_r.out_y ||
                    got_r.out_z !== exp_r.out_z || got_r.segment !== exp_r.segment ||
                    got_r.status !== exp_r.status)
                begin
                    err_count++;
                    if (err_count <= 10)
                    begin
                        $display("[%0t] result mismatch (result %0d)", $realtime,
                                 results_checked);
                        $display("    expected x=%h y=%h z=%h seg=%0d status=%0d",
                                 exp_r.out_x, exp_r.out_y, exp_r.out_z,
                                 exp_r.segment, exp_r.status);
                        $display("    actual   x=%h y=%h z=%h seg=%0d status=%0d",
                                 got_r.out_x, got_r.out_y, got_r.out_z,
                                 got_r.segment, got_r.status);
                    end
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still owed",
                     cycle_count, answers_due.size());
            $display("** keyframe_vector_lerp_unit: FAILED **");
            $finish;
        end
    end

    // Queue a keyframe write. The query time carries noise.
    task automatic push_write(input int unsigned idx,
                              input logic [kvl_pkg::TIME_W-1:0] t,
                              input logic [kvl_pkg::VAL_W-1:0] x,
                              input logic [kvl_pkg::VAL_W-1:0] y,
                              input logic [kvl_pkg::VAL_W-1:0] z);
        kvl_pkg::req_item_t it;
        it.func       = kvl_pkg::FUNC_WRITE;
        it.key_index  = kvl_pkg::INDEX_W'(idx);
        it.key_time   = t;
        it.key_x      = x;
        it.key_y      = y;
        it.key_z      = z;
        it.query_time = $urandom();
        plan_time[idx] = t;
        items_to_send.push_back(it);
        writes_sent++;
    endtask

    // Queue a query; the key fields are ignored by the block and get noise.
    task automatic push_query(input logic [kvl_pkg::TIME_W-1:0] q);
        kvl_pkg::req_item_t it;
        it.func       = kvl_pkg::FUNC_QUERY;
        it.key_index  = kvl_pkg::INDEX_W'($urandom_range(NKEYS - 1));
        it.key_time   = $urandom();
        it.key_x      = $urandom();
        it.key_y      = $urandom();
        it.key_z      = $urandom();
        it.query_time = q;
        items_to_send.push_back(it);
        queries_sent++;
    endtask

    // Wait for the block to go idle: nothing left to send, nothing owed, and
    // enough extra cycles for a trailing write to land.
    task automatic drain_block();
        while (items_to_send.size() != 0 || req.valid || answers_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Program key_count on an idle block and pick the idle pattern for the
    // phase that follows.
    task automatic set_key_count(input int unsigned n, input int unsigned idle_mode);
        @(posedge clk);
        key_count_we    <= 1'b1;
        key_count_wdata <= kvl_pkg::KEY_COUNT_W'(n);
        track_len = n;
        @(posedge clk);
        key_count_we <= 1'b0;
        @(negedge clk);
        case (idle_mode)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 53; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 53; end
            default: begin req_idle_pct = 32; rsp_stall_pct = 32; end
        endcase
        settings_used++;
    endtask

    // Write slots 0..n-1 with ascending times at a random base and spacing.
    // Now and then one key is pulled back onto or below its neighbor so that
    // a segment becomes flat or backward.
    task automatic build_track(input int unsigned n);
        longint unsigned t;
        longint unsigned gap_max;
        int unsigned     k;
        t = $urandom();
        if ($urandom_range(9) == 0)
            t = $urandom_range(3);
        if (t > 64'hFFFF_FFFF - n)
            t = 64'hFFFF_FFFF - n;
        gap_max = (64'hFFFF_FFFF - t) / ((n > 1) ? n - 1 : 1);
        case ($urandom_range(3))
            0: if (gap_max > 16) gap_max = 16;
            1: if (gap_max > 65536) gap_max = 65536;
            default: ;
        endcase
        for (k = 0; k < n; k++)
        begin
            push_write(k, kvl_pkg::TIME_W'(t), $urandom(), $urandom(), $urandom());
            t = t + 1 + ({32'b0, $urandom()} % gap_max);
        end
        if (n > 1 && $urandom_range(99) < 15)
        begin
            k = $urandom_range(n - 1, 1);
            push_write(k, plan_time[k - 1] - $urandom_range(1, 0), $urandom(), $urandom(),
                       $urandom());
        end
    endtask

    // Aim a query at a key, just beside one, inside a segment, across the
    // whole track, or anywhere at all.
    function automatic logic [kvl_pkg::TIME_W-1:0] pick_query(input int unsigned n);
        int unsigned     k;
        longint unsigned lo;
        longint unsigned hi;
        if (n == 0)
            return $urandom();
        k = $urandom_range(n - 1);
        case ($urandom_range(5))
            0: return plan_time[k];
            1: return plan_time[k] + 1;
            2: return plan_time[k] - 1;
            3:
            begin
                lo = plan_time[0];
                hi = plan_time[n - 1];
            end
            4: return $urandom();
            default:
            begin
                lo = plan_time[k];
                hi = (k + 1 < n) ? plan_time[k + 1] : plan_time[k];
            end
        endcase
        if (hi <= lo)
            return $urandom();
        return kvl_pkg::TIME_W'(lo + ({32'b0, $urandom()} % (hi - lo + 1)));
    endfunction

    initial
    begin
        int unsigned random_items;
        int unsigned phase;
        int unsigned n;
        int unsigned n_eff;
        int unsigned phase_items;
        int unsigned j;
        int unsigned idx;

        rst_n           = 1'b0;
        key_count_we    = 1'b0;
        key_count_wdata = '0;
        hold_off_go     = 1'b0;
        req_idle_pct    = 0;
        rsp_stall_pct   = 0;
        track_len       = 0;
        err_count       = 0;
        results_checked = 0;
        writes_sent     = 0;
        queries_sent    = 0;
        settings_used   = 0;
        status_seen     = '{default: 0};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An empty track after reset must report an error.
        push_query(32'hFFFF_FFFF);
        drain_block();

        // Single key with x and y at their extremes, queried at the lowest and highest times.
        set_key_count(1, 0);
        push_write(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        push_query(32'h0000_0000);
        push_query(32'hFFFF_FFFF);
        drain_block();

        // Three keys with full-scale swings: before the start, exactly on
        // keys, mid-segment, the end of the track and past it.
        set_key_count(3, 0);
        push_write(0, 32'h0000_0010, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        push_write(1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_write(2, 32'hFFFF_FF00, 32'h1234_5678, 32'hFFFF_FFFB, 32'h7FFF_FFFF);
        push_query(32'h0000_0000);
        push_query(32'h0000_0010);
        push_query(32'h4000_0008);
        push_query(32'h8000_0000);
        push_query(32'hFFFF_FF00);
        push_query(32'hFFFF_FFFF);
        drain_block();

        // A fourth key on the same time as the third makes the last segment
        // flat; moving it far back makes it run backward.
        push_write(3, 32'hFFFF_FF00, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003);
        drain_block();
        set_key_count(4, 0);
        push_query(32'hFFFF_FFFF);
        push_query(32'h0000_0005);
        push_write(3, 32'h0000_0020, 32'hFFFF_0000, 32'h0001_0000, 32'h8000_0001);
        push_query(32'hFFFF_FFFF);
        push_query(32'h0000_0018);
        drain_block();

        // Random phases. Each one programs a key count, builds a fresh track
        // in the slots it reads, then mixes queries with stray writes. The
        // first two phases take the top of the register and a full track.
        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (phase == 0)
                n = 127;
            else if (phase == 1)
                n = NKEYS;
            else
            begin
                j = $urandom_range(99);
                if (j < 4)
                    n = 0;
                else if (j < 12)
                    n = 1;
                else if (j < 70)
                    n = $urandom_range(8, 2);
                else if (j < 85)
                    n = $urandom_range(NKEYS - 1, 9);
                else if (j < 93)
                    n = NKEYS;
                else
                    n = $urandom_range(127, NKEYS + 1);
            end
            n_eff = (n > NKEYS) ? NKEYS : n;
            set_key_count(n, phase % 4);
            build_track(n_eff);
            random_items += n_eff;

            // Early on, freeze the result side for a long stretch while
            // queries keep coming, so the block fills and stalls its input.
            if (phase == 5)
                hold_off_go = 1'b1;

            phase_items = $urandom_range(50, 20);
            for (j = 0; j < phase_items; j++)
            begin
                if ($urandom_range(99) < 10)
                begin
                    idx = $urandom_range(NKEYS - 1);
                    if ($urandom_range(1) == 0)
                        push_write(idx, plan_time[idx], $urandom(), $urandom(), $urandom());
                    else
                        push_write(idx, $urandom(), $urandom(), $urandom(), $urandom());
                end
                else
                begin
                    push_query(pick_query(n_eff));
                end
            end
            random_items += phase_items;
            drain_block();
            phase++;
        end

        $display("Checked %0d results from %0d writes and %0d queries over %0d key counts",
                 results_checked, writes_sent, queries_sent, settings_used);
        $display("Status mix: ok %0d, before start %0d, after end %0d, error %0d",
                 status_seen[kvl_pkg::STATUS_OK], status_seen[kvl_pkg::STATUS_BEFORE],
                 status_seen[kvl_pkg::STATUS_AFTER], status_seen[kvl_pkg::STATUS_ERR]);
        $display("Mismatches: %0d", err_count);
        if (err_count == 0 && answers_due.size() == 0)
            $display("** keyframe_vector_lerp_unit: PASSED **");
        else
            $display("** keyframe_vector_lerp_unit: FAILED **");
        $finish;
    end

endmodule
